@@ rtl/assert_macros.svh @@
// assertion shorthands, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SLE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SLE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sle_pkg.sv @@
package sle_pkg;

    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_CHAR = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_BS    = 8'h08;
    localparam logic [7:0] CHR_DEL   = 8'h7F;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_TILDE = 8'h7E;

    typedef enum logic [1:0] {
        ECHO_CHAR,
        ECHO_ERASE,
        ECHO_EOL
    } echo_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ECHO,
        ST_TRIM_RD,
        ST_TRIM_CHK,
        ST_EMIT_RD,
        ST_EMIT_WR,
        ST_END
    } state_t;

    typedef struct packed {
        logic      store;
        logic      erase;
        logic      start_echo;
        echo_sel_t echo_sel;
        logic      push_echo;
        logic      last;
        logic      trim_init;
        logic      rd_trim;
        logic      len_dec;
        logic      emit_init;
        logic      rd_emit;
        logic      push_char;
        logic      push_end;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_eol;
        logic is_erase;
        logic is_print;
        logic fill_nz;
        logic room;
        logic enable;
        logic slot_free;
        logic echo_done;
        logic len_zero;
        logic rd_space;
        logic pos_last;
    } dp_status_t;

    function automatic logic [7:0] echo_byte(echo_sel_t sel, logic [1:0] idx,
                                             logic [7:0] ch);
        logic [7:0] b;
        case (sel)
            ECHO_CHAR:  b = ch;
            ECHO_ERASE: b = (idx == 2'd1) ? CHR_SPACE : CHR_BS;
            ECHO_EOL:   b = (idx == 2'd0) ? CHR_CR : CHR_LF;
            default:    b = ch;
        endcase
        return b;
    endfunction

    function automatic logic [1:0] echo_last_idx(echo_sel_t sel);
        logic [1:0] n;
        case (sel)
            ECHO_CHAR:  n = 2'd0;
            ECHO_ERASE: n = 2'd2;
            ECHO_EOL:   n = 2'd1;
            default:    n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

@@ rtl/sle_dp.sv @@
module sle_dp #(
    parameter int LINE_DEPTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            rx_byte,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  line_delivery_enable,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            out_kind,
    output logic [7:0]            out_byte,
    output logic                  out_last,
    input  sle_pkg::ctrl_cmd_t    cmd,
    output sle_pkg::dp_status_t   status
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam logic [AW-1:0] FULL_CNT = AW'(LINE_DEPTH - 1);

    logic [6:0]          mem [LINE_DEPTH];
    logic [6:0]          rd_data_reg;
    logic [AW-1:0]       rd_addr;

    logic [AW-1:0]       fill_reg, fill_next;
    logic [AW-1:0]       len_reg, len_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic                enable_reg, enable_next;
    sle_pkg::echo_sel_t  echo_sel_reg, echo_sel_next;
    logic [1:0]          echo_idx_reg, echo_idx_next;
    logic [7:0]          echo_char_reg, echo_char_next;
    logic                out_valid_reg, out_valid_next;
    logic [1:0]          out_kind_reg, out_kind_next;
    logic [7:0]          out_byte_reg, out_byte_next;
    logic                out_last_reg, out_last_next;
    logic                load;

    assign cfg_ready = 1'b1;

    // line store
    assign rd_addr = cmd.rd_trim ? (len_reg - AW'(1)) : pos_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            mem[fill_reg] <= rx_byte[6:0];
        end
        if (cmd.rd_trim || cmd.rd_emit)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign load = cmd.push_echo || cmd.push_char || cmd.push_end;

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.store)
            fill_next = fill_reg + AW'(1);
        else if (cmd.erase)
            fill_next = fill_reg - AW'(1);
        else if (cmd.push_end)
            fill_next = '0;

        enable_next = cfg_valid ? line_delivery_enable : enable_reg;

        echo_sel_next  = echo_sel_reg;
        echo_char_next = echo_char_reg;
        echo_idx_next  = echo_idx_reg;
        if (cmd.start_echo)
        begin
            echo_sel_next  = cmd.echo_sel;
            echo_char_next = rx_byte;
            echo_idx_next  = 2'd0;
        end
        else if (cmd.push_echo)
        begin
            echo_idx_next = echo_idx_reg + 2'd1;
        end

        len_next = len_reg;
        if (cmd.trim_init)
            len_next = fill_reg;
        else if (cmd.len_dec)
            len_next = len_reg - AW'(1);

        pos_next = pos_reg;
        if (cmd.emit_init)
            pos_next = '0;
        else if (cmd.push_char)
            pos_next = pos_reg + AW'(1);

        out_valid_next = load ? 1'b1 : (out_valid_reg && out_stall);
        out_kind_next  = out_kind_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (cmd.push_echo)
        begin
            out_kind_next = sle_pkg::KIND_ECHO;
            out_byte_next = sle_pkg::echo_byte(echo_sel_reg, echo_idx_reg, echo_char_reg);
            out_last_next = cmd.last;
        end
        else if (cmd.push_char)
        begin
            out_kind_next = sle_pkg::KIND_CHAR;
            out_byte_next = {1'b0, rd_data_reg};
            out_last_next = 1'b0;
        end
        else if (cmd.push_end)
        begin
            out_kind_next = sle_pkg::KIND_END;
            out_byte_next = 8'h00;
            out_last_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            enable_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            echo_idx_reg  <= 2'd0;
            echo_sel_reg  <= sle_pkg::ECHO_CHAR;
            len_reg       <= '0;
            pos_reg       <= '0;
        end
        else
        begin
            fill_reg      <= fill_next;
            enable_reg    <= enable_next;
            out_valid_reg <= out_valid_next;
            echo_idx_reg  <= echo_idx_next;
            echo_sel_reg  <= echo_sel_next;
            len_reg       <= len_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        echo_char_reg <= echo_char_next;
        out_kind_reg  <= out_kind_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    always_comb
    begin
        status.is_eol    = (rx_byte == sle_pkg::CHR_CR) || (rx_byte == sle_pkg::CHR_LF);
        status.is_erase  = (rx_byte == sle_pkg::CHR_BS) || (rx_byte == sle_pkg::CHR_DEL);
        status.is_print  = (rx_byte >= sle_pkg::CHR_SPACE) && (rx_byte <= sle_pkg::CHR_TILDE);
        status.fill_nz   = (fill_reg != '0);
        status.room      = (fill_reg != FULL_CNT);
        status.enable    = enable_reg;
        status.slot_free = !out_valid_reg || !out_stall;
        status.echo_done = (echo_idx_reg == sle_pkg::echo_last_idx(echo_sel_reg));
        status.len_zero  = (len_reg == '0);
        status.rd_space  = ({1'b0, rd_data_reg} == sle_pkg::CHR_SPACE);
        status.pos_last  = (pos_reg == (len_reg - AW'(1)));
    end

endmodule

@@ rtl/sle_ctrl.sv @@
module sle_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  sle_pkg::dp_status_t  status,
    output sle_pkg::ctrl_cmd_t   cmd
);

    sle_pkg::state_t state_reg, state_next;
    logic            deliver_reg, deliver_next;
    logic            idle;

    assign idle     = (state_reg == sle_pkg::ST_IDLE);
    assign in_stall = !idle;

    always_comb
    begin
        state_next   = state_reg;
        deliver_next = deliver_reg;
        case (state_reg)
            sle_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    deliver_next = status.is_eol && status.fill_nz && status.enable;
                    if (status.is_eol
                        || (status.is_erase && status.fill_nz)
                        || (status.is_print && status.room))
                        state_next = sle_pkg::ST_ECHO;
                end
            end
            sle_pkg::ST_ECHO:
            begin
                if (status.slot_free && status.echo_done)
                    state_next = deliver_reg ? sle_pkg::ST_TRIM_RD : sle_pkg::ST_IDLE;
            end
            sle_pkg::ST_TRIM_RD:
            begin
                state_next = status.len_zero ? sle_pkg::ST_END : sle_pkg::ST_TRIM_CHK;
            end
            sle_pkg::ST_TRIM_CHK:
            begin
                state_next = status.rd_space ? sle_pkg::ST_TRIM_RD : sle_pkg::ST_EMIT_RD;
            end
            sle_pkg::ST_EMIT_RD:
            begin
                state_next = sle_pkg::ST_EMIT_WR;
            end
            sle_pkg::ST_EMIT_WR:
            begin
                if (status.slot_free)
                    state_next = status.pos_last ? sle_pkg::ST_END : sle_pkg::ST_EMIT_RD;
            end
            sle_pkg::ST_END:
            begin
                if (status.slot_free)
                    state_next = sle_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sle_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            sle_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (status.is_eol)
                    begin
                        cmd.start_echo = 1'b1;
                        cmd.echo_sel   = sle_pkg::ECHO_EOL;
                    end
                    else if (status.is_erase && status.fill_nz)
                    begin
                        cmd.erase      = 1'b1;
                        cmd.start_echo = 1'b1;
                        cmd.echo_sel   = sle_pkg::ECHO_ERASE;
                    end
                    else if (status.is_print && status.room)
                    begin
                        cmd.store      = 1'b1;
                        cmd.start_echo = 1'b1;
                        cmd.echo_sel   = sle_pkg::ECHO_CHAR;
                    end
                end
            end
            sle_pkg::ST_ECHO:
            begin
                cmd.push_echo = status.slot_free;
                cmd.last      = status.echo_done && !deliver_reg;
                cmd.trim_init = status.slot_free && status.echo_done && deliver_reg;
            end
            sle_pkg::ST_TRIM_RD:
            begin
                cmd.rd_trim = !status.len_zero;
            end
            sle_pkg::ST_TRIM_CHK:
            begin
                cmd.len_dec   = status.rd_space;
                cmd.emit_init = !status.rd_space;
            end
            sle_pkg::ST_EMIT_RD:
            begin
                cmd.rd_emit = 1'b1;
            end
            sle_pkg::ST_EMIT_WR:
            begin
                cmd.push_char = status.slot_free;
            end
            sle_pkg::ST_END:
            begin
                cmd.push_end = status.slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sle_pkg::ST_IDLE;
            deliver_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            deliver_reg <= deliver_next;
        end
    end

endmodule

@@ rtl/serial_line_editor_with_echo.sv @@
// Terminal line editor with echo.
// Input channel: rx_byte with in_valid/in_stall; a byte is taken when in_valid
// is high and in_stall low. in_stall is high while a byte is being worked on.
// Output channel: out_kind/out_byte/out_last with out_valid/out_stall; each
// transaction is one echo byte, one delivered line character or the end marker,
// and out_last marks the final transaction caused by an input byte.
// Config channel: line_delivery_enable with cfg_valid/cfg_ready, always ready;
// write it only while the editor is idle.
// Sequence: the byte is taken in the idle state and its echo bytes are sent
// from the echo state; a stored character, an erase or an undelivered line
// end returns to idle from there. A line end with delivery then scans back
// from the line end, reading and checking each character and dropping trailing
// spaces, reads and sends each kept character in turn and then sends the end
// marker; the line store has one registered read port, so each read and the
// use of its data fall in separate states.
// Reset clears the fill count, the delivery enable and the output register;
// the line store holds no meaningful data until written.
// A stalled receiver holds the output register; the editor waits with it and
// keeps in_stall high until the last result of the current byte is in the output register.
module serial_line_editor_with_echo #(
    parameter int LINE_DEPTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       line_delivery_enable,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] out_kind,
    output logic [7:0] out_byte,
    output logic       out_last
);

    sle_pkg::ctrl_cmd_t  cmd;
    sle_pkg::dp_status_t status;

    sle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    sle_dp #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .rx_byte              (rx_byte),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .line_delivery_enable (line_delivery_enable),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .out_kind             (out_kind),
        .out_byte             (out_byte),
        .out_last             (out_last),
        .cmd                  (cmd),
        .status               (status)
    );

endmodule

@@ rtl/sle_chk.sv @@
`include "assert_macros.svh"

module sle_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] rx_byte,
    input logic       cfg_valid,
    input logic       cfg_ready,
    input logic       line_delivery_enable,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] out_kind,
    input logic [7:0] out_byte,
    input logic       out_last
);

    // end marker carries a zero byte and closes the transaction group
    `SLE_ASSERT_IMP(a_end_marker, out_valid && (out_kind == sle_pkg::KIND_END), (out_byte == 8'h00) && out_last, "end marker malformed")

    // delivered characters are printable and never last
    `SLE_ASSERT_IMP(a_line_char, out_valid && (out_kind == sle_pkg::KIND_CHAR), (out_byte >= sle_pkg::CHR_SPACE) && (out_byte <= sle_pkg::CHR_TILDE) && !out_last, "bad line character")

    // a carriage return echo is never marked last: its line feed always follows
    `SLE_ASSERT_IMP(a_cr_not_last, out_valid && (out_kind == sle_pkg::KIND_ECHO) && (out_byte == sle_pkg::CHR_CR), !out_last, "cr echo marked last")

    // stalled output transaction holds
    `SLE_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_kind) && $stable(out_byte) && $stable(out_last), "stalled output changed")

endmodule

bind serial_line_editor_with_echo sle_chk u_sle_chk (.*);

@@ tb/sv/tb_serial_line_editor_with_echo.sv @@
module tb_serial_line_editor_with_echo;

    localparam int LINE_DEPTH     = 32;
    localparam int IDLE_PAUSE     = 40;
    localparam int DRAIN_PAUSE    = 200;
    localparam int HOLD_OFF_LEN   = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 12;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic       last;
    } editor_result_t;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_ALTERNATE
    } stall_pattern_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid             = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte              = 8'h00;
    logic       cfg_valid            = 1'b0;
    logic       cfg_ready;
    logic       line_delivery_enable = 1'b0;
    logic       out_valid;
    logic       out_stall            = 1'b0;
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic       out_last;

    // bytes waiting to be sent and results the editor still owes
    logic [7:0]     rx_backlog[$];
    editor_result_t editor_output_q[$];

    // shadow of the editor state
    logic [6:0] line_chars[LINE_DEPTH];
    logic [5:0] line_len     = '0;
    logic       delivery_on  = 1'b0;

    int mismatch_count = 0;
    int line_items     = 0;
    int burst_left     = 0;
    int gap_left       = 0;
    int hold_left      = 0;
    int mode_left      = 0;
    int idle_cycles    = 0;
    bit hold_off_req   = 1'b0;
    bit alt_phase      = 1'b0;

    stall_pattern_t stall_pattern = STALL_NONE;
    logic           next_valid;
    logic [7:0]     next_byte;
    logic           next_stall;
    editor_result_t got;
    editor_result_t want;

    serial_line_editor_with_echo #(
        .LINE_DEPTH(LINE_DEPTH)
    ) dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .rx_byte             (rx_byte),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .line_delivery_enable(line_delivery_enable),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .out_kind            (out_kind),
        .out_byte            (out_byte),
        .out_last            (out_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic predict_line_editor(input logic [7:0] b);
        editor_result_t res[$];
        int             n;
        int             i;
        if (b == sle_pkg::CHR_CR || b == sle_pkg::CHR_LF)
        begin
            res.push_back('{sle_pkg::KIND_ECHO, sle_pkg::CHR_CR, 1'b0});
            res.push_back('{sle_pkg::KIND_ECHO, sle_pkg::CHR_LF, 1'b0});
            if (line_len != 0 && delivery_on)
            begin
                n = line_len;
                while (n > 0 && {1'b0, line_chars[n - 1]} == sle_pkg::CHR_SPACE)
                    n--;
                for (i = 0; i < n; i++)
                    res.push_back('{sle_pkg::KIND_CHAR, {1'b0, line_chars[i]}, 1'b0});
                res.push_back('{sle_pkg::KIND_END, 8'h00, 1'b0});
                line_len = '0;
            end
        end
        else if (b == sle_pkg::CHR_BS || b == sle_pkg::CHR_DEL)
        begin
            if (line_len != 0)
            begin
                line_len = line_len - 6'd1;
                res.push_back('{sle_pkg::KIND_ECHO, sle_pkg::CHR_BS, 1'b0});
                res.push_back('{sle_pkg::KIND_ECHO, sle_pkg::CHR_SPACE, 1'b0});
                res.push_back('{sle_pkg::KIND_ECHO, sle_pkg::CHR_BS, 1'b0});
            end
        end
        else if (b >= sle_pkg::CHR_SPACE && b <= sle_pkg::CHR_TILDE)
        begin
            if (line_len < LINE_DEPTH - 1)
            begin
                line_chars[line_len] = b[6:0];
                line_len = line_len + 6'd1;
                res.push_back('{sle_pkg::KIND_ECHO, b, 1'b0});
            end
        end
        if (res.size() > 0)
            res[res.size() - 1].last = 1'b1;
        foreach (res[i])
            editor_output_q.push_back(res[i]);
    endtask

    // sender: bursts of random length, random gaps in between
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte  <= 8'h00;
        end
        else
        begin
            next_valid = in_valid;
            next_byte  = rx_byte;
            if (in_valid && !in_stall)
            begin
                predict_line_editor(rx_byte);
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (rx_backlog.size() > 0)
                begin
                    next_valid = 1'b1;
                    next_byte  = rx_backlog.pop_front();
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 12);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                               : $urandom_range(0, 4);
                end
            end
            in_valid <= next_valid;
            rx_byte  <= next_byte;
        end
    end

    // receiver stall pattern, with a long hold-off when requested
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_OFF_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                next_stall = 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_pattern = stall_pattern_t'($urandom_range(0, 3));
                    mode_left     = $urandom_range(16, 80);
                end
                mode_left--;
                alt_phase = ~alt_phase;
                case (stall_pattern)
                    STALL_NONE:  next_stall = 1'b0;
                    STALL_LIGHT: next_stall = ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: next_stall = ($urandom_range(0, 9) < 7);
                    default:     next_stall = alt_phase;
                endcase
            end
            out_stall <= next_stall;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{out_kind, out_byte, out_last};
            if (editor_output_q.size() == 0)
            begin
                $display("%0t: unexpected transaction kind=%0d byte=%02h last=%0b",
                         $time, got.kind, got.ch, got.last);
                mismatch_count++;
            end
            else
            begin
                want = editor_output_q.pop_front();
                if (got.kind !== want.kind || got.ch !== want.ch || got.last !== want.last)
                begin
                    $display("%0t: mismatch expected kind=%0d byte=%02h last=%0b, %s",
                             $time, want.kind, want.ch, want.last,
                             $sformatf("actual kind=%0d byte=%02h last=%0b",
                                       got.kind, got.ch, got.last));
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("serial_line_editor_with_echo test failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic wait_editor_idle();
        do
            @(posedge clk);
        while (rx_backlog.size() != 0 || in_valid || editor_output_q.size() != 0);
        repeat (IDLE_PAUSE) @(posedge clk);
    endtask

    task automatic set_line_delivery(input logic en);
        @(posedge clk);
        cfg_valid            <= 1'b1;
        line_delivery_enable <= en;
        do
            @(posedge clk);
        while (!cfg_ready);
        delivery_on = en;
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_bytes(input logic [7:0] bytes[$]);
        foreach (bytes[i])
            rx_backlog.push_back(bytes[i]);
    endtask

    // one typed line: mostly printable, some spaces, erases and noise
    task automatic queue_random_line(input bit long_line);
        int         len;
        int         i;
        int         pick;
        logic [7:0] b;
        if (long_line)
            len = $urandom_range(31, 36);
        else if ($urandom_range(0, 4) == 0)
            len = $urandom_range(0, 2);
        else
            len = $urandom_range(1, 12);
        for (i = 0; i < len; i++)
        begin
            pick = long_line ? $urandom_range(2, 19) : $urandom_range(0, 19);
            if (pick == 0)
                b = $urandom_range(0, 1) ? sle_pkg::CHR_BS : sle_pkg::CHR_DEL;
            else if (pick == 1)
            begin
                b = $urandom_range(0, 1) ? 8'($urandom_range(128, 255))
                                         : 8'($urandom_range(0, 31));
                if (b == sle_pkg::CHR_CR || b == sle_pkg::CHR_LF || b == sle_pkg::CHR_BS)
                    b = 8'h1B;
            end
            else if (pick <= 4)
                b = sle_pkg::CHR_SPACE;
            else
                b = 8'($urandom_range(33, 126));
            if (pick != 1)
                line_items++;
            rx_backlog.push_back(b);
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
            begin
                rx_backlog.push_back(sle_pkg::CHR_SPACE);
                line_items++;
            end
        // some lines are left open and run into the next one
        if ($urandom_range(0, 7) != 0)
        begin
            rx_backlog.push_back($urandom_range(0, 1) ? sle_pkg::CHR_CR : sle_pkg::CHR_LF);
            line_items++;
        end
    endtask

    initial
    begin
        int phase;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // edge cases with delivery on: ignored bytes, erase and line end on an
        // empty line, extremes of the printable range, all-space line, trimming
        set_line_delivery(1'b1);
        queue_bytes('{8'h00, 8'hFF, sle_pkg::CHR_DEL, sle_pkg::CHR_BS,
                      sle_pkg::CHR_CR, sle_pkg::CHR_LF,
                      sle_pkg::CHR_SPACE, sle_pkg::CHR_TILDE, "A", sle_pkg::CHR_BS,
                      sle_pkg::CHR_CR,
                      sle_pkg::CHR_SPACE, sle_pkg::CHR_SPACE, sle_pkg::CHR_SPACE,
                      sle_pkg::CHR_LF,
                      "a", "b", sle_pkg::CHR_SPACE, sle_pkg::CHR_SPACE,
                      sle_pkg::CHR_CR, 8'h1B});

        // delivery off keeps the line, turning it back on delivers it
        wait_editor_idle();
        set_line_delivery(1'b0);
        queue_bytes('{"h", "i", sle_pkg::CHR_CR, "!"});
        wait_editor_idle();
        set_line_delivery(1'b1);
        queue_bytes('{sle_pkg::CHR_CR});

        for (phase = 0; phase < 4; phase++)
        begin
            wait_editor_idle();
            case (phase)
                0:       set_line_delivery(1'b1);
                1:       set_line_delivery(1'b0);
                2:       set_line_delivery(1'b1);
                default: set_line_delivery(1'($urandom_range(0, 1)));
            endcase
            line_items = 0;
            // in phase 0 the first line is long enough to fill or overrun the buffer
            queue_random_line(phase == 0);
            while (line_items < PHASE_ITEMS)
                queue_random_line($urandom_range(0, 9) == 0);
            if (phase == 2)
                hold_off_req = 1'b1;
        end

        do
            @(posedge clk);
        while (rx_backlog.size() != 0 || in_valid || editor_output_q.size() != 0);
        repeat (DRAIN_PAUSE) @(posedge clk);

        if (mismatch_count == 0 && editor_output_q.size() == 0)
            $display("serial_line_editor_with_echo test passed");
        else
            $display("serial_line_editor_with_echo test failed");
        $finish;
    end

endmodule
